FILE: rtl/block_chain_allocation_table_core_defines.svh
// ----------------------------------------------------------------------------
// block chain allocation table: assertion macros
// shared property forms for the table core checks
// ----------------------------------------------------------------------------
`ifndef BLOCK_CHAIN_ALLOCATION_TABLE_CORE_DEFINES_SVH
`define BLOCK_CHAIN_ALLOCATION_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define BCAT_ASSERT_NOW(lbl, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("bcat check failed");

// next-cycle implication
`define BCAT_ASSERT_NEXT(lbl, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("bcat check failed");

`endif

FILE: rtl/bcat_pkg.sv
// ----------------------------------------------------------------------------
// bcat_pkg
// types, codes and defaults for the block chain allocation table
// ----------------------------------------------------------------------------
package bcat_pkg;

    localparam int TABLE_BLOCKS_DEF = 1024;
    localparam int MAX_CHAIN_DEF    = 64;

    localparam logic [10:0] BLOCK_COUNT_RST = 11'd1024;

    localparam logic [2:0] OP_ALLOC     = 3'd0;
    localparam logic [2:0] OP_FREE      = 3'd1;
    localparam logic [2:0] OP_WALK      = 3'd2;
    localparam logic [2:0] OP_APPEND    = 3'd3;
    localparam logic [2:0] OP_FREE_LAST = 3'd4;

    localparam logic [1:0] STAT_OK           = 2'd0;
    localparam logic [1:0] STAT_NO_SPACE     = 2'd1;
    localparam logic [1:0] STAT_ALREADY_FREE = 2'd2;
    localparam logic [1:0] STAT_EMPTY        = 2'd3;

    typedef struct packed {
        logic [2:0] operation;
        logic [9:0] head_block;
        logic [6:0] chain_length;
        logic [6:0] extra_blocks;
    } bcat_in_t;

    typedef struct packed {
        logic [9:0]  block_number;
        logic        last;
        logic [1:0]  status;
        logic [10:0] free_blocks;
    } bcat_out_t;

    typedef struct packed {
        logic      valid;
        bcat_out_t data;
    } bcat_emit_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_WNEXT,
        S_WCHK,
        S_WFIN,
        S_FLEND,
        S_RESP,
        S_SCAN,
        S_SEND
    } bcat_state_t;

endpackage

FILE: rtl/bcat_link_mem.sv
// ----------------------------------------------------------------------------
// bcat_link_mem
// link table storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module bcat_link_mem
    import bcat_pkg::*;
#(
    parameter int TABLE_BLOCKS = TABLE_BLOCKS_DEF,
    parameter int IDX_W        = $clog2(TABLE_BLOCKS),
    parameter int EW           = IDX_W + 2
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [EW-1:0]    wdata,
    input  logic [IDX_W-1:0] raddr,
    output logic [EW-1:0]    rdata
);

    logic [EW-1:0] mem [TABLE_BLOCKS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/bcat_ctrl.sv
// ----------------------------------------------------------------------------
// bcat_ctrl
// sequencer over the link table: clearing pass, chain walk and first-fit scan
// ----------------------------------------------------------------------------
module bcat_ctrl
    import bcat_pkg::*;
#(
    parameter int TABLE_BLOCKS = TABLE_BLOCKS_DEF,
    parameter int MAX_CHAIN    = MAX_CHAIN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  bcat_in_t    req,
    input  logic        cfg_valid,
    input  logic [10:0] cfg_data,
    input  logic        out_free,
    output bcat_emit_t  emit
);

    localparam int IDX_W = $clog2(TABLE_BLOCKS);
    localparam int EW    = IDX_W + 2;
    localparam int CW    = $clog2(TABLE_BLOCKS + 1);
    localparam int NW    = (CW > 11) ? CW : 11;
    localparam logic [NW-1:0]    TB_N    = NW'(TABLE_BLOCKS);
    localparam logic [NW-1:0]    RST_N_V = (NW'(BLOCK_COUNT_RST) > TB_N) ? TB_N
                                                                    : NW'(BLOCK_COUNT_RST);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_BLOCKS - 1);
    localparam logic [6:0]       MAX_C    = 7'(MAX_CHAIN);
    localparam logic [EW-1:0]    ENT_FREE = {1'b1, 1'b0, {IDX_W{1'b0}}};
    localparam logic [EW-1:0]    ENT_END  = {1'b0, 1'b1, {IDX_W{1'b0}}};

    bcat_state_t      state_reg, state_next;
    logic [10:0]      bc_reg, bc_next;
    logic [NW-1:0]    free_reg, free_next;
    logic [2:0]       op_reg, op_next;
    logic [6:0]       len_reg, len_next;
    logic [6:0]       extra_reg, extra_next;
    logic [6:0]       limit_reg, limit_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic [6:0]       got_reg, got_next;
    logic [6:0]       target_reg, target_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [IDX_W-1:0] prev_reg, prev_next;
    logic [EW-1:0]    ent_reg, ent_next;
    logic [IDX_W-1:0] rd_addr_reg, rd_addr_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] found_reg, found_next;
    logic [1:0]       stat_reg, stat_next;

    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [EW-1:0]    wdata;
    logic [EW-1:0]    rdata;

    logic [NW-1:0]    usable;
    logic [NW-1:0]    cfg_sat;
    logic [NW-1:0]    ent_next_idx;
    logic             rd_free;
    logic             cont;

    bcat_link_mem #(
        .TABLE_BLOCKS (TABLE_BLOCKS),
        .IDX_W        (IDX_W),
        .EW           (EW)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_addr_next),
        .rdata (rdata)
    );

    assign usable  = (NW'(bc_reg) > TB_N) ? TB_N : NW'(bc_reg);
    assign cfg_sat = (NW'(cfg_data) > TB_N) ? TB_N : NW'(cfg_data);
    assign rd_free = rdata[EW-1];
    assign ent_next_idx = NW'(ent_reg[IDX_W-1:0]);
    assign cont = (cnt_reg < limit_reg) && !ent_reg[EW-2] && !ent_reg[EW-1]
                  && (ent_next_idx < usable);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            bc_reg    <= BLOCK_COUNT_RST;
            free_reg  <= RST_N_V;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bc_reg    <= bc_next;
            free_reg  <= free_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        len_reg     <= len_next;
        extra_reg   <= extra_next;
        limit_reg   <= limit_next;
        cnt_reg     <= cnt_next;
        got_reg     <= got_next;
        target_reg  <= target_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        ent_reg     <= ent_next;
        rd_addr_reg <= rd_addr_next;
        found_reg   <= found_next;
        stat_reg    <= stat_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        bc_next      = bc_reg;
        free_next    = free_reg;
        op_next      = op_reg;
        len_next     = len_reg;
        extra_next   = extra_reg;
        limit_next   = limit_reg;
        cnt_next     = cnt_reg;
        got_next     = got_reg;
        target_next  = target_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        ent_next     = ent_reg;
        rd_addr_next = rd_addr_reg;
        idx_next     = idx_reg;
        found_next   = found_reg;
        stat_next    = stat_reg;
        we           = 1'b0;
        waddr        = cur_reg;
        wdata        = ENT_FREE;
        req_ready    = 1'b0;
        emit         = '0;
        emit.data.free_blocks = free_reg[10:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                waddr    = idx_reg;
                wdata    = ENT_FREE;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next    = req.operation;
                    len_next   = req.chain_length;
                    extra_next = req.extra_blocks;
                    limit_next = (req.chain_length > MAX_C) ? MAX_C : req.chain_length;
                    stat_next  = STAT_OK;
                    if (req.operation > OP_FREE_LAST)
                    begin
                        state_next = S_RESP;
                    end
                    else if (req.operation == OP_ALLOC)
                    begin
                        if (req.chain_length == 7'd0)
                        begin
                            stat_next  = STAT_EMPTY;
                            state_next = S_RESP;
                        end
                        else if ((req.chain_length > MAX_C)
                                 || (free_reg < NW'(req.chain_length)))
                        begin
                            stat_next  = STAT_NO_SPACE;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            free_next    = free_reg - NW'(req.chain_length);
                            target_next  = req.chain_length;
                            got_next     = '0;
                            idx_next     = '0;
                            rd_addr_next = '0;
                            state_next   = S_SCAN;
                        end
                    end
                    else if (NW'(req.head_block) >= usable)
                    begin
                        stat_next  = STAT_ALREADY_FREE;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        rd_addr_next = IDX_W'(req.head_block);
                        state_next   = S_HEAD;
                    end
                end
            end

            S_HEAD:
            begin
                if (rd_free)
                begin
                    stat_next  = STAT_ALREADY_FREE;
                    state_next = S_RESP;
                end
                else if (len_reg == 7'd0)
                begin
                    stat_next  = STAT_EMPTY;
                    state_next = S_RESP;
                end
                else if ((op_reg == OP_APPEND) && (extra_reg == 7'd0))
                begin
                    state_next = S_RESP;
                end
                else if ((op_reg == OP_APPEND)
                         && (((8'(len_reg) + 8'(extra_reg)) > 8'(MAX_C))
                             || (free_reg < NW'(extra_reg))))
                begin
                    stat_next  = STAT_NO_SPACE;
                    state_next = S_RESP;
                end
                else
                begin
                    cur_next   = rd_addr_reg;
                    ent_next   = rdata;
                    cnt_next   = 7'd1;
                    state_next = S_WNEXT;
                end
            end

            S_WNEXT:
            begin
                if (cont)
                begin
                    rd_addr_next = ent_reg[IDX_W-1:0];
                    state_next   = S_WCHK;
                end
                else
                begin
                    state_next = S_WFIN;
                end
            end

            S_WCHK:
            begin
                if (rd_free)
                begin
                    state_next = S_WFIN;
                end
                else if ((op_reg != OP_WALK) || out_free)
                begin
                    if (op_reg == OP_WALK)
                    begin
                        emit.valid             = 1'b1;
                        emit.data.block_number = 10'(cur_reg);
                    end
                    if (op_reg == OP_FREE)
                    begin
                        we        = 1'b1;
                        free_next = free_reg + 1'b1;
                    end
                    prev_next  = cur_reg;
                    cur_next   = rd_addr_reg;
                    ent_next   = rdata;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_WNEXT;
                end
            end

            S_WFIN:
            begin
                unique case (op_reg)
                    OP_WALK:
                    begin
                        if (out_free)
                        begin
                            emit.valid             = 1'b1;
                            emit.data.block_number = 10'(cur_reg);
                            emit.data.last         = 1'b1;
                            state_next             = S_IDLE;
                        end
                    end
                    OP_APPEND:
                    begin
                        free_next    = free_reg - NW'(extra_reg);
                        target_next  = extra_reg;
                        got_next     = '0;
                        idx_next     = '0;
                        rd_addr_next = '0;
                        state_next   = S_SCAN;
                    end
                    default:
                    begin
                        // free chain and free last both release the final block reached
                        we        = 1'b1;
                        free_next = free_reg + 1'b1;
                        if ((op_reg == OP_FREE_LAST) && (cnt_reg != 7'd1))
                        begin
                            state_next = S_FLEND;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end
                endcase
            end

            S_FLEND:
            begin
                we         = 1'b1;
                waddr      = prev_reg;
                wdata      = ENT_END;
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    emit.valid       = 1'b1;
                    emit.data.last   = 1'b1;
                    emit.data.status = stat_reg;
                    state_next       = S_IDLE;
                end
            end

            S_SCAN:
            begin
                if (!rd_free)
                begin
                    idx_next     = idx_reg + 1'b1;
                    rd_addr_next = idx_reg + 1'b1;
                end
                else if ((got_reg == 7'd0) || out_free)
                begin
                    // link the previous block (or the chain tail on append) to this one
                    if (got_reg != 7'd0)
                    begin
                        we                     = 1'b1;
                        waddr                  = found_reg;
                        wdata                  = {2'b00, idx_reg};
                        emit.valid             = 1'b1;
                        emit.data.block_number = 10'(found_reg);
                    end
                    else if (op_reg == OP_APPEND)
                    begin
                        we    = 1'b1;
                        waddr = cur_reg;
                        wdata = {2'b00, idx_reg};
                    end
                    found_next = idx_reg;
                    got_next   = got_reg + 1'b1;
                    if (7'(got_reg + 1'b1) == target_reg)
                    begin
                        state_next = S_SEND;
                    end
                    else
                    begin
                        idx_next     = idx_reg + 1'b1;
                        rd_addr_next = idx_reg + 1'b1;
                    end
                end
            end

            S_SEND:
            begin
                if (out_free)
                begin
                    we                     = 1'b1;
                    waddr                  = found_reg;
                    wdata                  = ENT_END;
                    emit.valid             = 1'b1;
                    emit.data.block_number = 10'(found_reg);
                    emit.data.last         = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // register write reformats the table
        if (cfg_valid)
        begin
            bc_next    = cfg_data;
            free_next  = cfg_sat;
            idx_next   = '0;
            state_next = S_CLEAR;
        end
    end

endmodule

FILE: rtl/block_chain_allocation_table_core.sv
// ----------------------------------------------------------------------------
// block_chain_allocation_table_core
// fat-style block link table with first-fit allocation and chain operations
// ----------------------------------------------------------------------------
// channels: req (valid/ready) takes one command, rsp (valid/ready) returns
// one or more result transfers, the final one flagged by last. cfg
// (valid/ready, always ready) writes block_count and reformats the table.
// one command at a time: req_ready is low from acceptance until the final
// result has been loaded into the output register.
// a rejected or unused command is answered with a single status result.
// chain operations walk one link at a time, reading each entry before
// following it. allocate and append scan the link table one entry per
// cycle from index 0, pausing on a found free block while the output
// register is held, until enough free blocks are found; the link table
// has a single read port.
// reset and every cfg transfer start a clearing pass that marks all
// entries free; req_ready stays low during it.
// a stalled receiver holds the output register; the sequencer waits with
// its next result until the register is taken.
// ----------------------------------------------------------------------------
module block_chain_allocation_table_core
    import bcat_pkg::*;
#(
    parameter int TABLE_BLOCKS = TABLE_BLOCKS_DEF,
    parameter int MAX_CHAIN    = MAX_CHAIN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  bcat_in_t    req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output bcat_out_t   rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);

`include "block_chain_allocation_table_core_defines.svh"

    logic       rsp_valid_reg;
    bcat_out_t  rsp_reg;
    logic       out_free;
    bcat_emit_t emit;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    bcat_ctrl #(
        .TABLE_BLOCKS (TABLE_BLOCKS),
        .MAX_CHAIN    (MAX_CHAIN)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_free  (out_free),
        .emit      (emit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            rsp_reg <= emit.data;
        end
    end

    // one command in flight at a time
    `BCAT_ASSERT_NEXT(a_one_cmd, req_valid && req_ready, !req_ready)
    // a register write always starts the clearing pass
    `BCAT_ASSERT_NEXT(a_cfg_clears, cfg_valid, !req_ready)
    // error and status results are single transfers
    `BCAT_ASSERT_NOW(a_stat_last, rsp_valid && (rsp.status != STAT_OK), rsp.last)
    `BCAT_ASSERT_NOW(a_stat_zero, rsp_valid && (rsp.status != STAT_OK), rsp.block_number == 10'd0)

endmodule

FILE: verif/bcat_checker.sv
// ----------------------------------------------------------------------------
// bcat_checker
// watches the request, result and config channels of the allocation table,
// keeps its own link table and free count, and compares every result
// transfer with the oldest predicted one
// ----------------------------------------------------------------------------
module bcat_checker
    import bcat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  bcat_in_t    req,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  bcat_out_t   rsp,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [10:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    localparam int NBLK  = 1024;
    localparam int CHMAX = 64;
    localparam logic [11:0] LNK_FREE = 12'hFFF;
    localparam logic [11:0] LNK_END  = 12'hFFE;

    logic [11:0] links [NBLK];
    logic [10:0] blocks_in_use;
    logic [10:0] free_now;
    bcat_out_t   result_q [$];

    function automatic int usable_blocks();
        return (blocks_in_use > NBLK) ? NBLK : int'(blocks_in_use);
    endfunction

    task automatic reformat(input logic [10:0] cnt);
        blocks_in_use = cnt;
        foreach (links[i]) links[i] = LNK_FREE;
        free_now = 11'(usable_blocks());
    endtask

    task automatic push_result(input int blk, input bit lst, input logic [1:0] st);
        bcat_out_t r;
        r.block_number = 10'(blk);
        r.last         = lst;
        r.status       = st;
        r.free_blocks  = free_now;
        result_q.push_back(r);
    endtask

    // follow a chain from a valid head, stopping early on bad links
    task automatic trace_chain(input int head, input int lim, ref int path[CHMAX],
                               output int cnt);
        int e;
        cnt = 1;
        path[0] = head;
        while (cnt < lim) begin
            e = int'(links[path[cnt-1]]);
            if (e >= usable_blocks() || links[e] == LNK_FREE) break;
            path[cnt] = e;
            cnt++;
        end
    endtask

    task automatic first_fit(input int want, ref int got_blk[CHMAX], output bit ok);
        int got;
        got = 0;
        for (int i = 0; i < usable_blocks() && got < want; i++)
            if (links[i] == LNK_FREE) begin
                got_blk[got] = i;
                got++;
            end
        ok = (got >= want);
        if (ok) begin
            for (int k = 0; k + 1 < want; k++) links[got_blk[k]] = 12'(got_blk[k+1]);
            links[got_blk[want-1]] = LNK_END;
            free_now = free_now - 11'(want);
        end
    endtask

    task automatic predict_command(input bcat_in_t c);
        int path [CHMAX];
        int fresh [CHMAX];
        int len, extra, lim, cnt, head;
        bit ok;
        len   = int'(c.chain_length);
        extra = int'(c.extra_blocks);
        head  = int'(c.head_block);
        if (c.operation > OP_FREE_LAST) begin
            push_result(0, 1, STAT_OK);
            return;
        end
        if (c.operation == OP_ALLOC) begin
            if (len == 0) push_result(0, 1, STAT_EMPTY);
            else if (len > CHMAX || free_now < len) push_result(0, 1, STAT_NO_SPACE);
            else begin
                first_fit(len, fresh, ok);
                if (!ok) push_result(0, 1, STAT_NO_SPACE);
                else for (int k = 0; k < len; k++) push_result(fresh[k], k == len-1, STAT_OK);
            end
            return;
        end
        if (head >= usable_blocks() || links[head] == LNK_FREE) begin
            push_result(0, 1, STAT_ALREADY_FREE);
            return;
        end
        if (len == 0) begin
            push_result(0, 1, STAT_EMPTY);
            return;
        end
        lim = (len > CHMAX) ? CHMAX : len;
        case (c.operation)
            OP_FREE: begin
                trace_chain(head, lim, path, cnt);
                for (int k = 0; k < cnt; k++) links[path[k]] = LNK_FREE;
                free_now = free_now + 11'(cnt);
                push_result(0, 1, STAT_OK);
            end
            OP_WALK: begin
                trace_chain(head, lim, path, cnt);
                for (int k = 0; k < cnt; k++) push_result(path[k], k == cnt-1, STAT_OK);
            end
            OP_APPEND: begin
                if (extra == 0) push_result(0, 1, STAT_OK);
                else if (len + extra > CHMAX || free_now < extra)
                    push_result(0, 1, STAT_NO_SPACE);
                else begin
                    trace_chain(head, lim, path, cnt);
                    first_fit(extra, fresh, ok);
                    if (!ok) push_result(0, 1, STAT_NO_SPACE);
                    else begin
                        links[path[cnt-1]] = 12'(fresh[0]);
                        for (int k = 0; k < extra; k++)
                            push_result(fresh[k], k == extra-1, STAT_OK);
                    end
                end
            end
            default: begin
                trace_chain(head, lim, path, cnt);
                if (cnt == 1) links[path[0]] = LNK_FREE;
                else begin
                    links[path[cnt-2]] = LNK_END;
                    links[path[cnt-1]] = LNK_FREE;
                end
                free_now = free_now + 11'd1;
                push_result(0, 1, STAT_OK);
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        reformat(BLOCK_COUNT_RST);
    end

    assign pending = result_q.size();

    always @(posedge clk) begin
        bcat_out_t w;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) reformat(cfg_data);
            if (rsp_valid && rsp_ready) begin
                if (result_q.size() == 0) report_mismatch("unexpected transfer", 1, 0);
                else begin
                    w = result_q.pop_front();
                    if (rsp.block_number !== w.block_number)
                        report_mismatch("block_number", rsp.block_number, w.block_number);
                    if (rsp.last !== w.last) report_mismatch("last", rsp.last, w.last);
                    if (rsp.status !== w.status) report_mismatch("status", rsp.status, w.status);
                    if (rsp.free_blocks !== w.free_blocks)
                        report_mismatch("free_blocks", rsp.free_blocks, w.free_blocks);
                end
            end
            if (req_valid && req_ready) predict_command(req);
        end
    end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives commands and config writes into the allocation table with random
// gaps and result stalls; the checker predicts and compares each result
// ----------------------------------------------------------------------------
module tb_top;
    import bcat_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    bcat_in_t    req;
    logic        rsp_valid;
    logic        rsp_ready;
    bcat_out_t   rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;
    int          fail_count;
    int          pending;

    // heads of chains believed live; staleness is fine, the checker tracks truth
    logic [9:0]  heads [$];
    logic [6:0]  head_len [$];

    block_chain_allocation_table_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    bcat_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver stalls, with stretches of none
    initial begin
        int g;
        rsp_ready = 1'b0;
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 9) < 3) rsp_ready <= 1'b1;
            else begin
                g = gap_len();
                if (g == 0) rsp_ready <= 1'b1;
                else begin
                    rsp_ready <= 1'b0;
                    repeat (g - 1) @(negedge clk);
                end
            end
        end
    end

    task automatic send_cmd(input logic [2:0] op, input logic [9:0] fb,
                            input logic [6:0] len, input logic [6:0] ext);
        int g;
        g = gap_len();
        repeat (g) @(negedge clk);
        req_valid <= 1'b1;
        req <= '{operation: op, head_block: fb, chain_length: len, extra_blocks: ext};
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        @(negedge clk);
        req_valid <= 1'b0;
        // the block drops req_ready after each transfer
        @(negedge clk);
    endtask

    task automatic drain();
        while (pending != 0) @(negedge clk);
        // status-only commands may still be in flight
        repeat (20) @(negedge clk);
    endtask

    task automatic write_count(input logic [10:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        heads.delete();
        head_len.delete();
    endtask

    // mostly well-formed commands on known chains, some noise
    task automatic random_cmd();
        int r, idx;
        logic [6:0] n;
        r = $urandom_range(0, 99);
        if (heads.size() == 0 || r < 30) begin
            n = (r < 3) ? 7'($urandom_range(65, 127)) : 7'($urandom_range(1, 12));
            if (r == 4) n = 7'd64;
            send_cmd(OP_ALLOC, 10'($urandom), n, 7'($urandom));
            return;
        end
        if (r >= 92) begin
            send_cmd(3'($urandom), 10'($urandom), 7'($urandom), 7'($urandom));
            return;
        end
        idx = $urandom_range(0, heads.size() - 1);
        n = ($urandom_range(0, 9) == 0) ? 7'($urandom) : head_len[idx];
        case ($urandom_range(0, 3))
            0: send_cmd(OP_WALK, heads[idx], n, 7'($urandom));
            1: send_cmd(OP_APPEND, heads[idx], n, 7'($urandom_range(0, 8)));
            2: send_cmd(OP_FREE_LAST, heads[idx], n, 7'($urandom));
            default: begin
                send_cmd(OP_FREE, heads[idx], n, 7'($urandom));
                heads.delete(idx);
                head_len.delete(idx);
            end
        endcase
    endtask

    // harvest heads of allocations from the result stream
    struct { logic valid; logic [9:0] blk; logic [6:0] cnt; } i_dut_alloc_first;
    logic [2:0] last_op;
    always @(posedge clk) begin
        if (req_valid && req_ready) begin
            last_op <= req.operation;
            i_dut_alloc_first.valid <= 1'b1;
            i_dut_alloc_first.cnt <= 7'd0;
        end
        else if (rsp_valid && rsp_ready && last_op == OP_ALLOC && rsp.status == STAT_OK)
        begin
            if (i_dut_alloc_first.valid) i_dut_alloc_first.blk <= rsp.block_number;
            i_dut_alloc_first.valid <= 1'b0;
            i_dut_alloc_first.cnt <= i_dut_alloc_first.cnt + 7'd1;
            if (rsp.last) begin
                heads.push_back(i_dut_alloc_first.valid ? rsp.block_number
                                                        : i_dut_alloc_first.blk);
                head_len.push_back(i_dut_alloc_first.cnt + 7'd1);
            end
        end
    end

    initial begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        last_op   = '0;
        i_dut_alloc_first = '{1'b0, 10'd0, 7'd0};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every operation, extremes and special cases
        send_cmd(OP_ALLOC, 10'd0, 7'd0, 7'd0);
        send_cmd(OP_ALLOC, 10'd0, 7'd65, 7'd0);
        send_cmd(OP_ALLOC, 10'h3FF, 7'd64, 7'h7F);
        send_cmd(OP_ALLOC, 10'd0, 7'd3, 7'd0);
        send_cmd(OP_WALK, 10'd0, 7'd127, 7'd0);
        send_cmd(OP_WALK, 10'd64, 7'd5, 7'd0);
        send_cmd(OP_WALK, 10'h3FF, 7'd5, 7'd0);
        send_cmd(OP_WALK, 10'd0, 7'd0, 7'd0);
        send_cmd(OP_APPEND, 10'd0, 7'd64, 7'd0);
        send_cmd(OP_APPEND, 10'd0, 7'd60, 7'd5);
        send_cmd(OP_APPEND, 10'd0, 7'd64, 7'd2);
        send_cmd(OP_APPEND, 10'd64, 7'd3, 7'd4);
        send_cmd(OP_WALK, 10'd64, 7'd10, 7'd0);
        send_cmd(OP_FREE_LAST, 10'd64, 7'd10, 7'd0);
        send_cmd(OP_FREE_LAST, 10'd66, 7'd1, 7'd0);
        send_cmd(OP_FREE, 10'd0, 7'd64, 7'd0);
        send_cmd(OP_FREE, 10'd0, 7'd64, 7'd0);
        send_cmd(3'd5, 10'd1, 7'd1, 7'd1);
        send_cmd(3'd7, 10'h3FF, 7'h7F, 7'h7F);
        drain();

        // several volume sizes, extremes included
        write_count(11'd0);
        send_cmd(OP_ALLOC, 10'd0, 7'd1, 7'd0);
        send_cmd(OP_WALK, 10'd0, 7'd1, 7'd0);
        write_count(11'd1);
        send_cmd(OP_ALLOC, 10'd0, 7'd1, 7'd0);
        send_cmd(OP_APPEND, 10'd0, 7'd1, 7'd1);
        send_cmd(OP_FREE_LAST, 10'd0, 7'd1, 7'd0);
        write_count(11'd2047);
        send_cmd(OP_ALLOC, 10'd0, 7'd2, 7'd0);
        send_cmd(OP_WALK, 10'h3FF, 7'd2, 7'd0);

        write_count(11'd40);
        repeat (70) random_cmd();
        // hold off until everything has come back
        drain();
        write_count(11'd1024);
        repeat (120) random_cmd();
        write_count(11'($urandom_range(1, 300)));
        repeat (70) random_cmd();
        drain();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #100000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
